FILE: design/ckpq_pkg.sv
// ckpq_pkg: shared types and codes for the composite-key priority queue.
// Holds the item structs, opcode and status codes and the sequencer states.
// No dependencies.
package ckpq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_SEARCH  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_SCAN  = 2'd2,
    S_FIN   = 2'd3
  } state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] entry_id;
    logic [7:0]  score;
    logic [19:0] waited;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_id;
    logic [7:0]  out_score;
    logic [19:0] out_waited;
  } out_item_t;

endpackage

FILE: design/composite_key_priority_queue.sv
// composite_key_priority_queue: bounded priority queue with update and search by id.
// Each accepted item scans every slot in S_SCAN and answers from S_FIN; an insert into
// a full queue and an extract from an empty one skip the scan. One item in flight: a
// new item is not taken until the last leaves S_FIN. The slot memory is scanned one
// slot per cycle. Reset (rst_n, synchronous): a clearing pass marks every slot free;
// in_ready stays low until it ends. Depends on ckpq_pkg.
module composite_key_priority_queue #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ckpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ckpq_pkg::out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = ID_BITS + 28;

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] id;
    logic [7:0]         score;
    logic [19:0]        waited;
  } slot_t;

  slot_t mem [CAPACITY];

  ckpq_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  slot_t               rd_data_r;
  logic                found_r, found_nxt;
  slot_t               best_r, best_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  ckpq_pkg::opcode_t   op_r, op_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [7:0]          sc_r, sc_nxt;
  logic [19:0]         wt_r, wt_nxt;
  logic                out_valid_r, out_valid_nxt;
  ckpq_pkg::out_item_t out_item_r, out_item_nxt;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  slot_t               wr_data;
  logic                out_free;
  logic [ID_BITS+15:0] id_in_ext;
  logic [ID_BITS+15:0] id_out_ext;
  logic [KW-1:0]       key_rd, key_best;

  assign in_ready  = (state_r == ckpq_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;

  assign id_in_ext  = {{ID_BITS{1'b0}}, in_item.entry_id};
  assign id_out_ext = {16'b0, best_r.id};

  // Lower score first, then longer wait, then smaller id: one unsigned compare.
  assign key_rd   = {rd_data_r.score, ~rd_data_r.waited, rd_data_r.id};
  assign key_best = {best_r.score, ~best_r.waited, best_r.id};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    occ_nxt       = occ_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    sc_nxt        = sc_r;
    wt_nxt        = wt_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ckpq_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(CAPACITY - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ckpq_pkg::S_IDLE;
        end
      end

      ckpq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_item.opcode;
          id_nxt     = id_in_ext[ID_BITS-1:0];
          sc_nxt     = in_item.score;
          wt_nxt     = in_item.waited;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          rd_vld_nxt = 1'b0;
          if ((in_item.opcode == ckpq_pkg::OP_INSERT && occ_r == CW'(CAPACITY)) ||
              (in_item.opcode == ckpq_pkg::OP_EXTRACT && occ_r == '0)) begin
            state_nxt = ckpq_pkg::S_FIN;
          end else begin
            state_nxt = ckpq_pkg::S_SCAN;
          end
        end
      end

      ckpq_pkg::S_SCAN: begin
        // read issued at cnt_r, data compared in the next cycle
        rd_vld_nxt = (cnt_r < CW'(CAPACITY));
        rd_idx_nxt = cnt_r[AW-1:0];
        if (cnt_r < CW'(CAPACITY)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          case (op_r)
            ckpq_pkg::OP_INSERT: begin
              if (!found_r && !rd_data_r.valid) begin
                found_nxt    = 1'b1;
                best_idx_nxt = rd_idx_r;
              end
            end
            ckpq_pkg::OP_EXTRACT: begin
              if (rd_data_r.valid && (!found_r || key_rd < key_best)) begin
                found_nxt    = 1'b1;
                best_nxt     = rd_data_r;
                best_idx_nxt = rd_idx_r;
              end
            end
            default: begin
              if (!found_r && rd_data_r.valid && rd_data_r.id == id_r) begin
                found_nxt    = 1'b1;
                best_nxt     = rd_data_r;
                best_idx_nxt = rd_idx_r;
              end
            end
          endcase
          if (rd_idx_r == AW'(CAPACITY - 1)) begin
            state_nxt = ckpq_pkg::S_FIN;
          end
        end
      end

      ckpq_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt            = '0;
          out_item_nxt.status     = ckpq_pkg::ST_OK;
          wr_addr                 = best_idx_r;
          state_nxt               = ckpq_pkg::S_IDLE;
          case (op_r)
            ckpq_pkg::OP_INSERT: begin
              if (found_r) begin
                wr_en   = 1'b1;
                wr_data = {1'b1, id_r, sc_r, wt_r};
                occ_nxt = occ_r + 1'b1;
              end else begin
                out_item_nxt.status = ckpq_pkg::ST_FULL;
              end
            end
            ckpq_pkg::OP_EXTRACT: begin
              if (found_r) begin
                wr_en                   = 1'b1;
                wr_data                 = best_r;
                wr_data.valid           = 1'b0;
                occ_nxt                 = occ_r - 1'b1;
                out_item_nxt.out_id     = id_out_ext[15:0];
                out_item_nxt.out_score  = best_r.score;
                out_item_nxt.out_waited = best_r.waited;
              end else begin
                out_item_nxt.status = ckpq_pkg::ST_EMPTY;
              end
            end
            ckpq_pkg::OP_UPDATE: begin
              if (found_r) begin
                wr_en   = 1'b1;
                wr_data = {1'b1, best_r.id, sc_r, wt_r};
              end else begin
                out_item_nxt.status = ckpq_pkg::ST_MISSING;
              end
            end
            default: begin
              if (found_r) begin
                out_item_nxt.out_id     = id_out_ext[15:0];
                out_item_nxt.out_score  = best_r.score;
                out_item_nxt.out_waited = best_r.waited;
              end else begin
                out_item_nxt.status = ckpq_pkg::ST_MISSING;
              end
            end
          endcase
        end
      end

      default: begin
        state_nxt = ckpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ckpq_pkg::S_CLEAR;
      cnt_r       <= '0;
      occ_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    sc_r       <= sc_nxt;
    wt_r       <= wt_nxt;
    out_item_r <= out_item_nxt;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[cnt_r[AW-1:0]];
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ckpq_pkg::S_FIN && out_free && op_r == ckpq_pkg::OP_INSERT && !found_r)
      |-> occ_r == CW'(CAPACITY))
    else $error("insert found no free slot below capacity");

  a_empty_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ckpq_pkg::S_FIN && out_free && op_r == ckpq_pkg::OP_EXTRACT && !found_r)
      |-> occ_r == '0)
    else $error("extract found nothing in a non-empty queue");

endmodule
